// ----- hdl/sorted_sparse_term_accumulator_macros.svh -----
// Assertion macros shared by the sorted sparse term accumulator RTL.
// No dependencies; included inside module bodies.
`ifndef SORTED_SPARSE_TERM_ACCUMULATOR_MACROS_SVH
`define SORTED_SPARSE_TERM_ACCUMULATOR_MACROS_SVH

// Check that is switched off while reset is held
`define SSTA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that also runs through reset
`define SSTA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/ssta_pkg.sv -----
// Shared types and constants of the sorted sparse term accumulator.
// No dependencies; used by ssta_cell, ssta_mul and the top level.
package ssta_pkg;

    // defaults of the top-level parameters
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int KEY_BITS_DEF    = 32;
    localparam int FACTOR_BITS_DEF = 32;

    // port field widths
    localparam int PORT_KEY_W = 32;
    localparam int PORT_FAC_W = 32;
    localparam int DATA_W     = PORT_KEY_W + PORT_FAC_W;
    localparam int ACT_W      = 2;
    localparam int STATUS_W   = 3;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD   = 2'd0,
        ACT_SUB   = 2'd1,
        ACT_SCALE = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED   = 3'd0,
        ST_MERGED     = 3'd1,
        ST_REMOVED    = 3'd2,
        ST_FULL       = 3'd3,
        ST_SAT        = 3'd4,
        ST_ZERO_SCALE = 3'd5,
        ST_TERM       = 3'd6,
        ST_EMPTY      = 3'd7
    } t_status;

    // what every cell does in a cycle
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_UPDATE,
        CELL_SHIFT,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        logic     capture;  // latch key compare flags
        t_cell_op op;
    } t_cell_cmd;

    typedef struct packed {
        logic used;  // cell holds a term
        logic gt;    // stored key above the compared key
        logic eq;    // stored key equals the compared key
    } t_cell_flags;

endpackage

// ----- hdl/sorted_sparse_term_accumulator.sv -----
// Top level of the sorted sparse term accumulator: cell chain, control FSM,
// output register. Depends on ssta_pkg, ssta_cell, ssta_mul and the macro header.
//
//  channel   direction  payload
//  s_axis    in         tuser: action[1:0]; tdata: term_key[31:0], term_factor[63:32]
//  m_axis    out        tuser: status[2:0]; tdata: out_key[31:0], out_factor[63:32];
//                       tlast: last
//
// Add / subtract: accept with key compare in every cell, gather of the matched
//   factor, then saturating add and chain shift once m_axis is free.
// Read: after the accept, one term per cycle while m_axis is not stalled (an
//   empty table gives ST_EMPTY); the chain shifts toward cell 0.
// Scale: accept, check, then per term a run of the shared shift-add multiplier
//   over the bits of |constant| and one chain rotation, then the result (right
//   after the check for a zero constant or an empty table).
// Reset (synchronous, active low) empties the table at once. A stalled m_axis
//   holds the chain; a new item is taken while the last result still waits.
module sorted_sparse_term_accumulator #(
    parameter int TABLE_DEPTH = ssta_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = ssta_pkg::KEY_BITS_DEF,
    parameter int FACTOR_BITS = ssta_pkg::FACTOR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ssta_pkg::DATA_W-1:0]   s_axis_tdata,   // term_key, term_factor
    input  logic [ssta_pkg::ACT_W-1:0]    s_axis_tuser,   // action
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ssta_pkg::DATA_W-1:0]   m_axis_tdata,   // out_key, out_factor
    output logic [ssta_pkg::STATUS_W-1:0] m_axis_tuser,   // status
    output logic                          m_axis_tlast    // last
);
    import ssta_pkg::*;
    `include "sorted_sparse_term_accumulator_macros.svh"

    localparam int D  = TABLE_DEPTH;
    localparam int K  = KEY_BITS;
    localparam int F  = FACTOR_BITS;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XK = (KEY_BITS > PORT_KEY_W) ? KEY_BITS : PORT_KEY_W;
    localparam int XW = (FACTOR_BITS > PORT_FAC_W) ? FACTOR_BITS : PORT_FAC_W;
    localparam logic [F-1:0]  FMAX   = {1'b0, {(F-1){1'b1}}};
    localparam logic [F-1:0]  FMIN   = {1'b1, {(F-1){1'b0}}};
    localparam logic [XW-1:0] FMAX_X = {{(XW-F+1){1'b0}}, {(F-1){1'b1}}};
    localparam logic [XW-1:0] FMIN_X = ~FMAX_X;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GATHER,
        S_APPLY,
        S_READ,
        S_SCALE_CHK,
        S_SCALE_START,
        S_SCALE_WAIT,
        S_SCALE_END
    } t_state;

    // control state
    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_rot_left, n_rot_left;
    logic                 r_sat_any, n_sat_any;
    logic                 r_out_valid;
    // item and gather registers
    t_action              r_act;
    logic [K-1:0]         r_key;
    logic [F-1:0]         r_fac;
    logic                 r_hit;
    logic [F-1:0]         r_hit_fac;
    // output register
    t_status              r_out_status;
    logic [PORT_KEY_W-1:0] r_out_key;
    logic [PORT_FAC_W-1:0] r_out_fac;
    logic                 r_out_last;

    // cell chain
    logic [K-1:0]         c_key   [D];
    logic [F-1:0]         c_fac   [D];
    t_cell_flags          c_flags [D];
    t_cell_cmd            w_cmd;
    logic [K-1:0]         w_new_key;
    logic [F-1:0]         w_new_fac;
    logic [D-1:0]         w_used;
    logic                 w_hit;
    logic [F-1:0]         w_hit_fac;

    // input conversion
    logic                 w_accept;
    logic [XK-1:0]        w_in_kx;
    logic [K-1:0]         w_in_key;
    logic signed [XW-1:0] w_in_fx;
    logic [XW-1:0]        w_in_fc;
    logic [F-1:0]         w_in_fac;

    // saturating add / subtract
    logic [F-1:0]         w_base;
    logic [F:0]           w_sum;
    logic                 w_ovf;
    logic [F-1:0]         w_v;

    // emit path
    logic                 w_out_free;
    logic                 w_emit;
    t_status              w_e_status;
    logic [K-1:0]         w_e_key;
    logic [F-1:0]         w_e_fac;
    logic                 w_e_last;
    logic [XK-1:0]        w_e_kx;
    logic signed [XW-1:0] w_e_fx;
    logic                 w_full;

    // multiplier
    logic                 w_mul_start;
    logic                 w_mul_done;
    logic [F-1:0]         w_mul_prod;
    logic                 w_mul_sat;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_full        = (r_count == CW'(D));

    // key masked to KEY_BITS, factor clamped to the FACTOR_BITS range
    assign w_in_kx  = XK'(s_axis_tdata[PORT_KEY_W-1:0]);
    assign w_in_key = w_in_kx[K-1:0];
    assign w_in_fx  = XW'($signed(s_axis_tdata[DATA_W-1:PORT_KEY_W]));
    assign w_in_fc  = (w_in_fx > $signed(FMAX_X)) ? FMAX_X :
                      (w_in_fx < $signed(FMIN_X)) ? FMIN_X : w_in_fx;
    assign w_in_fac = w_in_fc[F-1:0];

    // cell row
    for (genvar g = 0; g < D; g++) begin : g_cell
        logic [K-1:0] w_lk, w_rk;
        logic [F-1:0] w_lf, w_rf;
        t_cell_flags  w_lfl, w_rfl;
        if (g == 0) begin : g_head
            assign w_lk  = '0;
            assign w_lf  = '0;
            assign w_lfl = '{used: 1'b1, gt: 1'b1, eq: 1'b0};
        end else begin : g_mid_l
            assign w_lk  = c_key[g-1];
            assign w_lf  = c_fac[g-1];
            assign w_lfl = c_flags[g-1];
        end
        if (g == D - 1) begin : g_tail
            assign w_rk  = '0;
            assign w_rf  = '0;
            assign w_rfl = '{used: 1'b0, gt: 1'b0, eq: 1'b0};
        end else begin : g_mid_r
            assign w_rk  = c_key[g+1];
            assign w_rf  = c_fac[g+1];
            assign w_rfl = c_flags[g+1];
        end
        ssta_cell #(
            .KEY_BITS    (KEY_BITS),
            .FACTOR_BITS (FACTOR_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_cmp_key     (w_in_key),
            .i_new_key     (w_new_key),
            .i_new_fac     (w_new_fac),
            .i_left_key    (w_lk),
            .i_left_fac    (w_lf),
            .i_left_flags  (w_lfl),
            .i_right_key   (w_rk),
            .i_right_fac   (w_rf),
            .i_right_flags (w_rfl),
            .o_key         (c_key[g]),
            .o_fac         (c_fac[g]),
            .o_flags       (c_flags[g])
        );
    end

    // matched factor (at most one cell hits) and occupancy vector
    always_comb begin
        w_hit     = 1'b0;
        w_hit_fac = '0;
        for (int i = 0; i < D; i++) begin
            w_hit     = w_hit | c_flags[i].eq;
            w_hit_fac = w_hit_fac | (c_fac[i] & {F{c_flags[i].eq}});
            w_used[i] = c_flags[i].used;
        end
    end

    // saturating combine; an absent key starts from zero
    assign w_base = r_hit ? r_hit_fac : '0;
    assign w_sum  = (r_act == ACT_SUB) ? ({w_base[F-1], w_base} - {r_fac[F-1], r_fac})
                                       : ({w_base[F-1], w_base} + {r_fac[F-1], r_fac});
    assign w_ovf  = w_sum[F] ^ w_sum[F-1];
    assign w_v    = w_ovf ? (w_sum[F] ? FMIN : FMAX) : w_sum[F-1:0];

    ssta_mul #(
        .FACTOR_BITS (FACTOR_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (c_fac[0]),
        .i_c     (r_fac),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod),
        .o_sat   (w_mul_sat)
    );

    // next-state, cell command and result selection
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rot_left  = r_rot_left;
        n_sat_any   = r_sat_any;
        w_cmd       = '{capture: w_accept, op: CELL_HOLD};
        w_new_key   = r_key;
        w_new_fac   = w_v;
        w_mul_start = 1'b0;
        w_emit      = 1'b0;
        w_e_status  = ST_MERGED;
        w_e_key     = r_key;
        w_e_fac     = r_fac;
        w_e_last    = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_action'(s_axis_tuser))
                        ACT_ADD, ACT_SUB: n_state = S_GATHER;
                        ACT_SCALE:        n_state = S_SCALE_CHK;
                        default:          n_state = S_READ;
                    endcase
                end
            end
            S_GATHER: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                    if (r_fac == '0) begin
                        // zero factor leaves the table alone
                        w_e_status = r_hit ? ST_MERGED : ST_REMOVED;
                        w_e_fac    = r_hit ? r_hit_fac : '0;
                    end else if (r_hit && w_v == '0) begin
                        w_cmd.op   = CELL_REMOVE;
                        n_count    = r_count - CW'(1);
                        w_e_status = ST_REMOVED;
                        w_e_fac    = '0;
                    end else if (r_hit) begin
                        w_cmd.op   = CELL_UPDATE;
                        w_e_status = w_ovf ? ST_SAT : ST_MERGED;
                        w_e_fac    = w_v;
                    end else if (w_full) begin
                        w_e_status = ST_FULL;
                        w_e_fac    = w_v;
                    end else begin
                        w_cmd.op   = CELL_INSERT;
                        n_count    = r_count + CW'(1);
                        w_e_status = w_ovf ? ST_SAT : ST_INSERTED;
                        w_e_fac    = w_v;
                    end
                end
            end
            S_READ: begin
                if (w_out_free) begin
                    w_emit = 1'b1;
                    if (!c_flags[0].used) begin
                        w_e_status = ST_EMPTY;
                        w_e_key    = '0;
                        w_e_fac    = '0;
                        n_state    = S_IDLE;
                    end else begin
                        w_cmd.op   = CELL_SHIFT;
                        n_count    = r_count - CW'(1);
                        w_e_status = ST_TERM;
                        w_e_key    = c_key[0];
                        w_e_fac    = c_fac[0];
                        w_e_last   = !c_flags[1].used;
                        if (!c_flags[1].used) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_SCALE_CHK: begin
                if (r_fac == '0 || r_count == '0) begin
                    if (w_out_free) begin
                        w_emit     = 1'b1;
                        w_e_status = (r_fac == '0) ? ST_ZERO_SCALE : ST_EMPTY;
                        w_e_key    = '0;
                        n_state    = S_IDLE;
                    end
                end else begin
                    n_rot_left = r_count;
                    n_sat_any  = 1'b0;
                    n_state    = S_SCALE_START;
                end
            end
            S_SCALE_START: begin
                w_mul_start = 1'b1;
                n_state     = S_SCALE_WAIT;
            end
            S_SCALE_WAIT: begin
                if (w_mul_done) begin
                    // head term leaves, scaled copy joins at the tail
                    w_cmd.op   = CELL_ROTATE;
                    w_new_key  = c_key[0];
                    w_new_fac  = w_mul_prod;
                    n_sat_any  = r_sat_any | w_mul_sat;
                    n_rot_left = r_rot_left - CW'(1);
                    n_state    = (r_rot_left == CW'(1)) ? S_SCALE_END : S_SCALE_START;
                end
            end
            S_SCALE_END: begin
                if (w_out_free) begin
                    w_emit     = 1'b1;
                    w_e_status = r_sat_any ? ST_SAT : ST_MERGED;
                    w_e_key    = '0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_e_kx = XK'(w_e_key);
    assign w_e_fx = XW'($signed(w_e_fac));

    // state, item capture and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rot_left  <= '0;
            r_sat_any   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_rot_left <= n_rot_left;
            r_sat_any  <= n_sat_any;
            if (w_accept) begin
                r_act <= t_action'(s_axis_tuser);
                r_key <= w_in_key;
                r_fac <= w_in_fac;
            end
            if (r_state == S_GATHER) begin
                r_hit     <= w_hit;
                r_hit_fac <= w_hit_fac;
            end
            if (w_emit) begin
                r_out_valid  <= 1'b1;
                r_out_status <= w_e_status;
                r_out_key    <= w_e_kx[PORT_KEY_W-1:0];
                r_out_fac    <= w_e_fx[PORT_FAC_W-1:0];
                r_out_last   <= w_e_last;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_fac, r_out_key};
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

    `SSTA_ASSERT(a_count_matches_cells, i_clk, i_rst_n, $countones(w_used) == 32'(r_count), "entry count and occupied cells differ")
    `SSTA_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(D), "entry count above table depth")
    `SSTA_ASSERT(a_mul_done_in_wait, i_clk, i_rst_n, w_mul_done |-> r_state == S_SCALE_WAIT, "multiplier result outside scale loop")
    `SSTA_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !r_out_valid && r_count == '0, "reset left state behind")

endmodule

// ----- hdl/ssta_cell.sv -----
// One cell of the sorted term chain: holds one key and factor.
// Depends on ssta_pkg; instantiated in a row by the top level.
module ssta_cell #(
    parameter int KEY_BITS    = ssta_pkg::KEY_BITS_DEF,
    parameter int FACTOR_BITS = ssta_pkg::FACTOR_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ssta_pkg::t_cell_cmd      i_cmd,
    input  logic [KEY_BITS-1:0]      i_cmp_key,
    input  logic [KEY_BITS-1:0]      i_new_key,
    input  logic [FACTOR_BITS-1:0]   i_new_fac,
    input  logic [KEY_BITS-1:0]      i_left_key,
    input  logic [FACTOR_BITS-1:0]   i_left_fac,
    input  ssta_pkg::t_cell_flags    i_left_flags,
    input  logic [KEY_BITS-1:0]      i_right_key,
    input  logic [FACTOR_BITS-1:0]   i_right_fac,
    input  ssta_pkg::t_cell_flags    i_right_flags,
    output logic [KEY_BITS-1:0]      o_key,
    output logic [FACTOR_BITS-1:0]   o_fac,
    output ssta_pkg::t_cell_flags    o_flags
);
    import ssta_pkg::*;

    logic                   r_used;
    logic                   r_gt;
    logic                   r_eq;
    logic [KEY_BITS-1:0]    r_key;
    logic [FACTOR_BITS-1:0] r_fac;

    // compare flags, then insert / remove / update / shift / rotate as commanded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_gt   <= 1'b0;
            r_eq   <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_gt <= r_used && (r_key > i_cmp_key);
                r_eq <= r_used && (r_key == i_cmp_key);
            end
            case (i_cmd.op)
                CELL_INSERT: begin
                    // cells below the insertion point move one place down
                    if (!r_gt) begin
                        if (i_left_flags.gt) begin
                            r_key  <= i_new_key;
                            r_fac  <= i_new_fac;
                            r_used <= 1'b1;
                        end else begin
                            r_key  <= i_left_key;
                            r_fac  <= i_left_fac;
                            r_used <= i_left_flags.used;
                        end
                    end
                end
                CELL_REMOVE: begin
                    // the matched cell and those below close the gap
                    if (!r_gt) begin
                        r_key  <= i_right_key;
                        r_fac  <= i_right_fac;
                        r_used <= i_right_flags.used;
                    end
                end
                CELL_UPDATE: begin
                    if (r_eq) begin
                        r_fac <= i_new_fac;
                    end
                end
                CELL_SHIFT: begin
                    r_key  <= i_right_key;
                    r_fac  <= i_right_fac;
                    r_used <= i_right_flags.used;
                end
                CELL_ROTATE: begin
                    // last occupied cell takes the scaled head term
                    if (r_used && !i_right_flags.used) begin
                        r_key <= i_new_key;
                        r_fac <= i_new_fac;
                    end else begin
                        r_key  <= i_right_key;
                        r_fac  <= i_right_fac;
                        r_used <= i_right_flags.used;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_key   = r_key;
    assign o_fac   = r_fac;
    assign o_flags = '{used: r_used, gt: r_gt, eq: r_eq};

endmodule

// ----- hdl/ssta_mul.sv -----
// Shift-add multiplier with signed saturation for the scale operation.
// Depends on ssta_pkg; one bit of the constant per cycle.
module ssta_mul #(
    parameter int FACTOR_BITS = ssta_pkg::FACTOR_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [FACTOR_BITS-1:0] i_a,
    input  logic [FACTOR_BITS-1:0] i_c,
    output logic                   o_done,
    output logic [FACTOR_BITS-1:0] o_prod,
    output logic                   o_sat
);
    import ssta_pkg::*;
    `include "sorted_sparse_term_accumulator_macros.svh"

    localparam int F  = FACTOR_BITS;
    localparam int PW = 2 * FACTOR_BITS;
    localparam logic [F-1:0]  FMAX    = {1'b0, {(F-1){1'b1}}};
    localparam logic [F-1:0]  FMIN    = {1'b1, {(F-1){1'b0}}};
    localparam logic [PW-1:0] LIM_POS = PW'(FMAX);
    localparam logic [PW-1:0] LIM_NEG = LIM_POS + PW'(1);

    logic          r_busy;
    logic          r_done;
    logic          r_neg;
    logic          r_sat;
    logic [F-1:0]  r_mc;
    logic [PW-1:0] r_add;
    logic [PW-1:0] r_acc;
    logic [F-1:0]  r_prod;

    logic [F-1:0]  w_ma;
    logic [F-1:0]  w_mc;
    logic          w_sat;
    logic [F-1:0]  w_mag;

    // operand magnitudes; the most negative value maps to 2^(F-1)
    assign w_ma  = i_a[F-1] ? (~i_a + F'(1)) : i_a;
    assign w_mc  = i_c[F-1] ? (~i_c + F'(1)) : i_c;
    assign w_sat = r_acc > (r_neg ? LIM_NEG : LIM_POS);
    assign w_mag = r_acc[F-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_mc   <= w_mc;
                r_add  <= PW'(w_ma);
                r_acc  <= '0;
                r_neg  <= i_a[F-1] ^ i_c[F-1];
            end else if (r_busy) begin
                if (r_mc == '0) begin
                    // product complete: clamp and sign
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_sat  <= w_sat;
                    if (w_sat) begin
                        r_prod <= r_neg ? FMIN : FMAX;
                    end else begin
                        r_prod <= r_neg ? (~w_mag + F'(1)) : w_mag;
                    end
                end else begin
                    if (r_mc[0]) begin
                        r_acc <= r_acc + r_add;
                    end
                    r_add <= r_add << 1;
                    r_mc  <= r_mc >> 1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;
    assign o_sat  = r_sat;

    `SSTA_ASSERT(a_start_idle, i_clk, i_rst_n, i_start |-> !r_busy, "mul started while busy")
    `SSTA_ASSERT(a_done_after_busy, i_clk, i_rst_n, r_done |-> $past(r_busy), "done without run")
    `SSTA_ASSERT(a_done_pulse, i_clk, i_rst_n, r_done |=> !r_done, "done longer than a cycle")

endmodule

// ----- tb/sorted_sparse_term_accumulator_tb.sv -----
// Self-checking testbench of the sorted sparse term accumulator: a term-table
// predictor, a bursty stream driver and a stalling result checker.
// Depends on ssta_pkg and the sorted_sparse_term_accumulator RTL.
`timescale 1ns / 1ps

module sorted_sparse_term_accumulator_tb;
    import ssta_pkg::*;

    localparam int     DEPTH   = TABLE_DEPTH_DEF;
    localparam longint FAC_MAX = 64'sd2147483647;
    localparam longint FAC_MIN = -FAC_MAX - 1;

    typedef struct {
        t_action            act;
        logic [31:0]        key;
        logic signed [31:0] fac;
    } t_term_cmd;

    typedef struct {
        t_status     status;
        logic [31:0] key;
        logic [31:0] factor;
        logic        last;
    } t_term_result;

    typedef enum {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_PULSE} t_sink_mode;
    typedef enum {EP_MIX, EP_FILL, EP_NOISE} t_episode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [DATA_W-1:0]      s_axis_tdata = '0;   // term_key, term_factor
    logic [ACT_W-1:0]       s_axis_tuser = '0;   // action
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [DATA_W-1:0]      m_axis_tdata;        // out_key, out_factor
    logic [STATUS_W-1:0]    m_axis_tuser;        // status
    logic                   m_axis_tlast;        // last

    // pending input transactions and outstanding expected results
    t_term_cmd    pending_terms[$];
    t_term_result expected_results[$];
    t_term_cmd    cur_cmd;
    int           n_issued = 0;
    int           n_accepted = 0;
    int           n_errors = 0;

    // predictor copy of the term table
    logic [31:0] tbl_key [DEPTH];
    longint      tbl_fac [DEPTH];
    int          tbl_count = 0;

    sorted_sparse_term_accumulator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // clamp to the signed factor range, flag saturation
    function automatic longint clamp_fac(input longint v, inout bit sat);
        if (v > FAC_MAX) begin
            sat = 1'b1;
            return FAC_MAX;
        end
        if (v < FAC_MIN) begin
            sat = 1'b1;
            return FAC_MIN;
        end
        return v;
    endfunction

    function automatic void push_result(input t_status st, input logic [31:0] key,
                                        input longint f, input bit last);
        t_term_result r;
        r.status = st;
        r.key    = key;
        r.factor = f[31:0];
        r.last   = last;
        expected_results.push_back(r);
    endfunction

    // table update for one accepted transaction
    task automatic merge_term(input t_term_cmd cmd);
        longint f;
        longint v;
        int     pos;
        bit     sat;
        f   = longint'(cmd.fac);
        sat = 1'b0;
        case (cmd.act)
            ACT_READ: begin
                if (tbl_count == 0)
                    push_result(ST_EMPTY, '0, 0, 1'b1);
                for (int i = 0; i < tbl_count; i++)
                    push_result(ST_TERM, tbl_key[i], tbl_fac[i], i == tbl_count - 1);
                tbl_count = 0;
            end
            ACT_SCALE: begin
                if (f == 0) begin
                    push_result(ST_ZERO_SCALE, '0, f, 1'b1);
                end else if (tbl_count == 0) begin
                    push_result(ST_EMPTY, '0, f, 1'b1);
                end else begin
                    for (int i = 0; i < tbl_count; i++)
                        tbl_fac[i] = clamp_fac(tbl_fac[i] * f, sat);
                    push_result(sat ? ST_SAT : ST_MERGED, '0, f, 1'b1);
                end
            end
            default: begin
                // find first entry with key not above the new key
                pos = 0;
                while (pos < tbl_count && tbl_key[pos] > cmd.key)
                    pos++;
                if (pos < tbl_count && tbl_key[pos] == cmd.key) begin
                    if (f == 0) begin
                        push_result(ST_MERGED, cmd.key, tbl_fac[pos], 1'b1);
                    end else begin
                        v = clamp_fac(cmd.act == ACT_ADD ? tbl_fac[pos] + f
                                                          : tbl_fac[pos] - f, sat);
                        if (v == 0) begin
                            for (int i = pos; i < tbl_count - 1; i++) begin
                                tbl_key[i] = tbl_key[i + 1];
                                tbl_fac[i] = tbl_fac[i + 1];
                            end
                            tbl_count--;
                            push_result(ST_REMOVED, cmd.key, 0, 1'b1);
                        end else begin
                            tbl_fac[pos] = v;
                            push_result(sat ? ST_SAT : ST_MERGED, cmd.key, v, 1'b1);
                        end
                    end
                end else if (f == 0) begin
                    push_result(ST_REMOVED, cmd.key, 0, 1'b1);
                end else begin
                    v = (cmd.act == ACT_ADD) ? f : clamp_fac(-f, sat);
                    if (tbl_count >= DEPTH) begin
                        push_result(ST_FULL, cmd.key, v, 1'b1);
                    end else begin
                        for (int i = tbl_count; i > pos; i--) begin
                            tbl_key[i] = tbl_key[i - 1];
                            tbl_fac[i] = tbl_fac[i - 1];
                        end
                        tbl_key[pos] = cmd.key;
                        tbl_fac[pos] = v;
                        tbl_count++;
                        push_result(sat ? ST_SAT : ST_INSERTED, cmd.key, v, 1'b1);
                    end
                end
            end
        endcase
    endtask

    function automatic void push_cmd(input t_action act, input logic [31:0] key,
                                     input logic signed [31:0] fac);
        t_term_cmd c;
        c.act = act;
        c.key = key;
        c.fac = fac;
        pending_terms.push_back(c);
    endfunction

    // keys: mostly random, sometimes the extremes
    function automatic logic [31:0] rand_key();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return 32'h0000_0000;
        if (r == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // factors: small values so merges cancel, plus full-range and extremes
    function automatic logic signed [31:0] rand_factor();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 4) return $urandom_range(0, 8) - 4;
        if (r <= 7) return $urandom;
        if (r == 8) return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        return ($urandom_range(0, 1) != 0) ? 32'sd1 : -32'sd1;
    endfunction

    function automatic logic signed [31:0] rand_scale();
        int r;
        r = $urandom_range(0, 7);
        if (r <= 5) return $urandom_range(0, 6) - 3;
        if (r == 6) return $urandom;
        return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endfunction

    // stimulus, reset and end of run
    initial begin : stimulus_proc
        logic [31:0] pool[$];
        t_episode    kind;
        bit          first_ep;
        int          r;
        logic [31:0] key;

        // directed: empty table, extremes, saturation, cancellation, all actions
        push_cmd(ACT_READ,  32'h0,         32'sd0);
        push_cmd(ACT_SCALE, 32'h0,         32'sd5);
        push_cmd(ACT_SCALE, 32'hFFFF_FFFF, 32'sd0);
        push_cmd(ACT_ADD,   32'h0,         32'sd1);
        push_cmd(ACT_ADD,   32'hFFFF_FFFF, 32'sh7FFF_FFFF);
        push_cmd(ACT_ADD,   32'hFFFF_FFFF, 32'sd1);
        push_cmd(ACT_SUB,   32'h8000_0000, 32'sh8000_0000);
        push_cmd(ACT_SUB,   32'h1234_5678, 32'sd5);
        push_cmd(ACT_ADD,   32'h1234_5678, 32'sd0);
        push_cmd(ACT_ADD,   32'h0000_BEEF, 32'sd0);
        push_cmd(ACT_ADD,   32'h1234_5678, 32'sd5);
        push_cmd(ACT_ADD,   32'hAAAA_AAAA, 32'sh8000_0000);
        push_cmd(ACT_SUB,   32'hAAAA_AAAA, 32'sd1);
        push_cmd(ACT_SCALE, 32'h0,         -32'sd1);
        push_cmd(ACT_SCALE, 32'h0,         32'sd3);
        push_cmd(ACT_ADD,   32'h5555_5555, 32'sd3);
        push_cmd(ACT_SUB,   32'h0,         32'sh7FFF_FFFF);
        push_cmd(ACT_READ,  32'h0,         32'sd0);
        push_cmd(ACT_SUB,   32'h0000_0001, -32'sd7);
        push_cmd(ACT_ADD,   32'h8000_0001, 32'sd2);
        push_cmd(ACT_SCALE, 32'h0,         -32'sd2);
        push_cmd(ACT_SUB,   32'h8000_0001, -32'sd4);
        push_cmd(ACT_READ,  32'h0,         32'sd0);

        // random episodes; fill and mix episodes end in a read-out
        first_ep = 1'b1;
        while (pending_terms.size() < 400) begin
            r = $urandom_range(0, 9);
            kind = first_ep ? EP_FILL : (r == 0) ? EP_FILL : (r <= 2) ? EP_NOISE : EP_MIX;
            first_ep = 1'b0;
            pool.delete();
            case (kind)
                EP_FILL: begin
                    // overfill the table, then touch it while full
                    repeat ($urandom_range(66, 72)) begin
                        key = $urandom;
                        pool.push_back(key);
                        push_cmd(ACT_ADD, key, $urandom | 32'd1);
                    end
                    repeat ($urandom_range(4, 10)) begin
                        key = ($urandom_range(0, 1) != 0) ? pool[$urandom_range(0, pool.size() - 1)]
                                                          : $urandom;
                        push_cmd(t_action'($urandom_range(0, 1)), key, rand_factor());
                    end
                    push_cmd(ACT_SCALE, $urandom, rand_scale());
                    push_cmd(ACT_READ, $urandom, $urandom);
                end
                EP_NOISE: begin
                    repeat ($urandom_range(3, 10))
                        push_cmd(t_action'($urandom_range(0, 3)), $urandom, $urandom);
                end
                default: begin
                    // small key pool so terms merge and cancel
                    repeat ($urandom_range(3, 14)) pool.push_back(rand_key());
                    repeat ($urandom_range(8, 30)) begin
                        r = $urandom_range(0, 19);
                        if (r < 8)
                            push_cmd(ACT_ADD, pool[$urandom_range(0, pool.size() - 1)],
                                     rand_factor());
                        else if (r < 15)
                            push_cmd(ACT_SUB, pool[$urandom_range(0, pool.size() - 1)],
                                     rand_factor());
                        else if (r < 17)
                            push_cmd(t_action'($urandom_range(0, 1)), rand_key(), rand_factor());
                        else if (r < 19)
                            push_cmd(ACT_SCALE, $urandom, rand_scale());
                        else
                            push_cmd(ACT_READ, $urandom, $urandom);
                    end
                    push_cmd(ACT_READ, $urandom, $urandom);
                end
            endcase
        end
        push_cmd(ACT_READ, 32'h0, 32'sd0);

        // hold reset, then release it on a falling clock edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // drain, then allow for stray results
        while (pending_terms.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin : watchdog_proc
        #100_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // input driver: bursts of transactions with random gaps
    always @(negedge i_clk) begin : drive_proc
        int        burst_left;
        int        gap_left;
        bit        next_valid;
        t_term_cmd c;
        next_valid = s_axis_tvalid;
        if (i_rst_n && !(s_axis_tvalid && n_accepted != n_issued)) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_terms.size() != 0) begin
                c = pending_terms.pop_front();
                cur_cmd      <= c;
                s_axis_tdata <= {c.fac, c.key};
                s_axis_tuser <= c.act;
                next_valid   = 1'b1;
                n_issued++;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
        s_axis_tvalid <= next_valid;
    end

    // result sink: stall pattern switches at random between four modes
    always @(negedge i_clk) begin : sink_proc
        t_sink_mode mode;
        int         mode_left;
        int         phase;
        if (mode_left <= 0) begin
            mode      = t_sink_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 150);
        end else begin
            mode_left--;
        end
        phase++;
        case (mode)
            SINK_OPEN:  m_axis_tready <= 1'b1;
            SINK_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
            SINK_HEAVY: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:    m_axis_tready <= (phase % 5 != 4);
        endcase
    end

    // predict on input transactions, check output transactions
    always @(posedge i_clk) begin : check_proc
        t_term_result want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                merge_term(cur_cmd);
                n_accepted <= n_accepted + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: status %0d key %08h factor %08h last %0b",
                           m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
                           m_axis_tlast);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tuser !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
                        n_errors++;
                    end
                    if (m_axis_tdata[31:0] !== want.key) begin
                        $error("out_key: expected %08h, actual %08h",
                               want.key, m_axis_tdata[31:0]);
                        n_errors++;
                    end
                    if (m_axis_tdata[63:32] !== want.factor) begin
                        $error("out_factor: expected %08h, actual %08h",
                               want.factor, m_axis_tdata[63:32]);
                        n_errors++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, m_axis_tlast);
                        n_errors++;
                    end
                end
            end
        end
    end

endmodule
